// File: src/dbd_pkg.sv
// Shared types, widths and constants for the day-difference pipeline.
// Used by dbd_ordinal and days_between_dates_top; depends on nothing.
package dbd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ORD_W   = 23;   // day ordinal, unsigned
  localparam int CNT_W   = 23;   // signed result field
  localparam int DIFF_W  = ORD_W + 1;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^15.
  localparam int RECIP_SHIFT = 24;
  localparam logic [17:0] RECIP_100 = 18'd167773;
  localparam int PROD_W = 33;
  localparam int Q100_W = PROD_W - RECIP_SHIFT;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic signed [DIFF_W-1:0] CNT_MAX = 24'sd4194303;
  localparam logic signed [DIFF_W-1:0] CNT_MIN = -24'sd4194304;

  typedef logic [ORD_W-1:0] ord_t;

  // Days in the months before the given month (0 is January), common year.
  function automatic logic [8:0] month_prefix(input logic [MONTH_W-1:0] idx);
    logic [8:0] days;
    unique case (idx)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd59;
      4'd3:    days = 9'd90;
      4'd4:    days = 9'd120;
      4'd5:    days = 9'd151;
      4'd6:    days = 9'd181;
      4'd7:    days = 9'd212;
      4'd8:    days = 9'd243;
      4'd9:    days = 9'd273;
      4'd10:   days = 9'd304;
      4'd11:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

// File: src/dbd_ordinal.sv
// Four-stage pipeline that turns one date into its day ordinal from year 0.
// Depends on dbd_pkg; stage enables come from the valid/ready chain of the top level.
module dbd_ordinal
  import dbd_pkg::*;
(
  input  logic               clk,
  input  logic [3:0]         stage_en,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  output ord_t               ordinal
);

  // Stage 1: month clamp, prefix lookup, year * 365 and rounding offsets.
  logic [MONTH_W-1:0] mon_c;
  logic [ORD_W-1:0]   y365;
  logic [YEAR_W:0]    y_ext;

  always_comb begin
    priority if (month < MONTH_JAN) begin
      mon_c = MONTH_JAN;
    end else if (month > MONTH_DEC) begin
      mon_c = MONTH_DEC;
    end else begin
      mon_c = month;
    end
  end

  assign y_ext = {1'b0, year};
  // 365 = 256 + 64 + 32 + 8 + 4 + 1
  assign y365 = (ORD_W'(year) << 8) + (ORD_W'(year) << 6) + (ORD_W'(year) << 5)
              + (ORD_W'(year) << 3) + (ORD_W'(year) << 2) + ORD_W'(year);

  logic [YEAR_W-1:0] y1_r;
  logic [YEAR_W:0]   a1_r, b1_r;
  logic [12:0]       q4_1_r;
  logic [8:0]        pre1_r;
  logic              feb1_r;
  logic [DAY_W-1:0]  d1_r;
  logic [ORD_W-1:0]  y365_1_r;
  logic [YEAR_W:0]   y_p3;

  assign y_p3 = y_ext + (YEAR_W+1)'(3);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      y1_r     <= year;
      a1_r     <= y_ext + (YEAR_W+1)'(99);
      b1_r     <= y_ext + (YEAR_W+1)'(399);
      q4_1_r   <= y_p3[YEAR_W:2];
      pre1_r   <= month_prefix(mon_c - MONTH_JAN);
      feb1_r   <= (mon_c > MONTH_FEB);
      d1_r     <= day;
      y365_1_r <= y365;
    end
  end

  // Stage 2: the two divisions by 100 as reciprocal multiplications.
  logic [PROD_W-1:0] p99, p399;
  assign p99  = PROD_W'(a1_r) * PROD_W'(RECIP_100);
  assign p399 = PROD_W'(b1_r) * PROD_W'(RECIP_100);

  logic [YEAR_W-1:0] y2_r;
  logic [Q100_W-1:0] q99_2_r, q399_2_r;
  logic [12:0]       q4_2_r;
  logic [8:0]        pre2_r;
  logic              feb2_r;
  logic [DAY_W-1:0]  d2_r;
  logic [ORD_W-1:0]  y365_2_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      y2_r     <= y1_r;
      q99_2_r  <= p99[PROD_W-1:RECIP_SHIFT];
      q399_2_r <= p399[PROD_W-1:RECIP_SHIFT];
      q4_2_r   <= q4_1_r;
      pre2_r   <= pre1_r;
      feb2_r   <= feb1_r;
      d2_r     <= d1_r;
      y365_2_r <= y365_1_r;
    end
  end

  // Stage 3: days in whole years before this one, and the leap flag.
  // ceil(y/100) * 100 == y exactly when y is a multiple of 100;
  // a multiple of 100 is a multiple of 400 when it is also one of 16.
  logic [YEAR_W+1:0] q99x100;
  logic              div100, leap;
  assign q99x100 = ((YEAR_W+2)'(q99_2_r) << 6) + ((YEAR_W+2)'(q99_2_r) << 5)
                 + ((YEAR_W+2)'(q99_2_r) << 2);
  assign div100  = (q99x100 == (YEAR_W+2)'(y2_r));
  assign leap    = (div100) ? (y2_r[3:0] == 4'd0) : (y2_r[1:0] == 2'd0);

  logic [ORD_W-1:0] base3_r;
  logic             leap3_r;
  logic [8:0]       pre3_r;
  logic [DAY_W-1:0] d3_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      base3_r <= y365_2_r + ORD_W'(q4_2_r) - ORD_W'(q99_2_r) + ORD_W'(q399_2_r >> 2);
      leap3_r <= leap & feb2_r;
      pre3_r  <= pre2_r;
      d3_r    <= d2_r;
    end
  end

  // Stage 4: add the month prefix, the leap day and the day of month.
  ord_t ord4_r;
  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      ord4_r <= base3_r + ORD_W'(pre3_r) + ORD_W'(leap3_r) + ORD_W'(d3_r);
    end
  end

  assign ordinal = ord4_r;

endmodule

// File: src/days_between_dates_top.sv
// Top level: signed Gregorian day count from a start date to an end date.
// Depends on dbd_pkg and dbd_ordinal (one instance per date).
//
//  channel | dir | tdata fields, lowest bit up
//  --------+-----+-----------------------------------------------------------
//  in_     | in  | start_year[13:0] start_month[17:14] start_day[22:18]
//          |     | end_year[36:23] end_month[40:37] end_day[45:41], pad to 48
//  out_    | out | day_count[22:0] (two's complement), pad to 24
//
// Five register stages: four in each ordinal pipeline, then difference and
// saturation into the output register. One beat per cycle while out_ is not stalled.
// Each stage has its own valid bit and loads when it is empty or the stage after
// it can load, so a stall on out_ fills bubbles first and never drops a beat.
// rst_n (synchronous) clears only the valid bits.
module days_between_dates_top
  import dbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // start_year, start_month, start_day,
                                  // end_year, end_month, end_day
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // day_count
);

  localparam int STAGES = 5;

  logic [STAGES-1:0] v_r, v_nxt;
  logic [STAGES-1:0] rdy;

  always_comb begin
    rdy[STAGES-1] = !v_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = rdy[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < STAGES; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = rdy[0];

  ord_t ord_s, ord_e;

  dbd_ordinal u_start (
    .clk      (clk),
    .stage_en (rdy[3:0]),
    .year     (in_tdata[13:0]),
    .month    (in_tdata[17:14]),
    .day      (in_tdata[22:18]),
    .ordinal  (ord_s)
  );

  dbd_ordinal u_end (
    .clk      (clk),
    .stage_en (rdy[3:0]),
    .year     (in_tdata[36:23]),
    .month    (in_tdata[40:37]),
    .day      (in_tdata[45:41]),
    .ordinal  (ord_e)
  );

  logic signed [DIFF_W-1:0] diff;
  logic [CNT_W-1:0]         cnt_nxt, cnt_r;

  assign diff = $signed({1'b0, ord_e}) - $signed({1'b0, ord_s});

  always_comb begin
    priority if (diff > CNT_MAX) begin
      cnt_nxt = CNT_MAX[CNT_W-1:0];
    end else if (diff < CNT_MIN) begin
      cnt_nxt = CNT_MIN[CNT_W-1:0];
    end else begin
      cnt_nxt = diff[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[STAGES-1]) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_tvalid = v_r[STAGES-1];
  assign out_tdata  = {1'b0, cnt_r};

endmodule

// File: src/dbd_checker.sv
// Port-level checks for days_between_dates_top, attached by the bind below.
// Depends only on the top level's ports.
module dbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat shown after reset");

  // When the output side is empty or moving, every stage can advance.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while the output is free");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result beat changed or dropped");

  // Padding above day_count stays zero on every result beat.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> (out_tdata[23] == 1'b0))
    else $error("padding bit set in result beat");

endmodule

bind days_between_dates_top dbd_checker u_dbd_checker (.*);
